// ===== hdl/mawd_pkg.sv =====
// shared constants of the acceleration magnitude window detector
package mawd_pkg;

  // default build parameters
  localparam int WINDOW_LENGTH_DEF = 30;
  localparam int SAMPLE_BITS_DEF   = 16;

  // configuration port
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_LEVEL  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_THRESHOLD = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] GRAVITY_LEVEL_RST  = CFG_W'(2048);
  localparam logic [CFG_W-1:0] ZERO_THRESHOLD_RST = CFG_W'(410);

  // result word
  localparam int AVG_W = 17;

endpackage

// ===== hdl/mawd_if.sv =====
// valid/ready channel interfaces for sample and result words
interface mawd_in_if #(
  parameter int SAMPLE_BITS = mawd_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] accel_x;
  logic signed [SAMPLE_BITS-1:0] accel_y;
  logic signed [SAMPLE_BITS-1:0] accel_z;

  modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
  modport sink   (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

interface mawd_out_if import mawd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [AVG_W-1:0] average_accel;
  logic                    apogee_detected;

  modport source (output valid, output average_accel, output apogee_detected, input ready);
  modport sink   (input valid, input average_accel, input apogee_detected, output ready);
endinterface

// ===== hdl/mawd_ram.sv =====
// generic single-write, single-read ram with registered read data
module mawd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/mawd_sqrt.sv =====
// bit-serial integer square root, one root bit per cycle, floor result
module mawd_sqrt #(
  parameter int ROOT_W = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [2*ROOT_W-1:0] radicand,
  output logic                done,
  output logic [ROOT_W-1:0]   root
);

  localparam int CW = (ROOT_W > 1) ? $clog2(ROOT_W) : 1;
  localparam logic [CW-1:0] LAST = CW'(ROOT_W - 1);

  logic                busy_r;
  logic                done_r;
  logic [CW-1:0]       cnt_r;
  logic [2*ROOT_W-1:0] rad_r;
  logic [ROOT_W:0]     rem_r;
  logic [ROOT_W-1:0]   root_r;

  logic [ROOT_W+2:0]   rem_sh;
  logic [ROOT_W+2:0]   trial;
  logic [ROOT_W+2:0]   diff;
  logic                take;

  // trial subtract of (root << 2) | 1 against the shifted remainder
  always_comb begin
    rem_sh = {rem_r, rad_r[2*ROOT_W-1 -: 2]};
    trial  = {1'b0, root_r, 2'b01};
    diff   = rem_sh - trial;
    take   = (rem_sh >= trial);
  end

  // iteration control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rad_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        rad_r <= {rad_r[2*ROOT_W-3:0], 2'b00};
        if (take) begin
          rem_r  <= diff[ROOT_W:0];
          root_r <= {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r  <= rem_sh[ROOT_W:0];
          root_r <= {root_r[ROOT_W-2:0], 1'b0};
        end
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== hdl/mawd_div.sv =====
// divider by a build-time constant through one reciprocal multiply, floor quotient
module mawd_div #(
  parameter int DVD_W   = 22,
  parameter int DIVISOR = 30
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  // floor(n / DIVISOR) equals (n * RECIP) >> SH for every n below 2**DVD_W
  localparam int SH = DVD_W + $clog2(DIVISOR);
  localparam int MW = DVD_W + 1;
  localparam int PW = DVD_W + MW;
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  logic             busy_r;
  logic             done_r;
  logic [DVD_W-1:0] dvd_r;
  logic [DVD_W-1:0] quo_r;

  logic [PW-1:0]    prod;

  // reciprocal product on the registered dividend
  always_comb begin
    prod = PW'(dvd_r) * PW'(RECIP);
  end

  // dividend register, quotient register in the cycle after
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        dvd_r  <= dividend;
      end else if (busy_r) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
        quo_r  <= DVD_W'(prod >> SH);
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== hdl/accel_magnitude_window_detector.sv =====
// Acceleration magnitude window detector. Each accepted word carries one
// three-axis sample; the block forms floor(sqrt(x*x + y*y + z*z)), subtracts
// gravity_level, replaces the oldest of WINDOW_LENGTH ring entries (all zero
// after reset) and returns the running sum divided by WINDOW_LENGTH, truncated
// toward zero, plus a flag for |average| < zero_threshold. One word is worked
// on at a time: a new word is accepted only once the last has reached the
// output register. The time is set by the bit-serial square root (one root
// bit per cycle); the squares go through one shared multiplier, one axis after
// another, and the division by WINDOW_LENGTH is a reciprocal multiply. A
// finished result sits in the output register, so the next word is taken while
// it waits; a word that finishes while the previous result still waits holds
// until it leaves. The ring lives in a ram; entries not yet written read as
// zero through a fill flag, so there is no clearing pass after reset.
module accel_magnitude_window_detector import mawd_pkg::*; #(
  parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF,
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  mawd_in_if.sink              in_ch,
  mawd_out_if.source           out_ch,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int MAXW  = (SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W;
  localparam int EW    = MAXW + 1;
  localparam int SUM_W = EW + $clog2(WINDOW_LENGTH + 1);
  localparam int RW    = 2 * SAMPLE_BITS;
  localparam int SLW   = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam logic [SLW-1:0] SLOT_LAST = SLW'(WINDOW_LENGTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_UPDATE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FINISH
  } state_t;

  state_t state_r;

  // configuration registers
  logic [CFG_W-1:0] gravity_r;
  logic [CFG_W-1:0] thresh_r;

  // sequencer and datapath registers
  logic [1:0]                   cnt_r;
  logic signed [SAMPLE_BITS-1:0] ax_r;
  logic signed [SAMPLE_BITS-1:0] ay_r;
  logic signed [SAMPLE_BITS-1:0] az_r;
  logic [RW-1:0]                prod_r;
  logic [RW-1:0]                acc_r;
  logic [SAMPLE_BITS-1:0]       mag_r;
  logic [SUM_W-1:0]             sum_r;
  logic [SLW-1:0]               slot_r;
  logic                         filled_r;
  logic                         neg_r;
  logic [SUM_W-1:0]             quo_r;
  logic                         out_valid_r;
  logic [AVG_W-1:0]             out_avg_r;
  logic                         out_flag_r;

  // combinational helpers
  logic signed [SAMPLE_BITS-1:0] sel;
  logic [SAMPLE_BITS-1:0]        op;
  logic [RW-1:0]                 prod_c;
  logic [EW-1:0]                 entry;
  logic [EW-1:0]                 old_c;
  logic [SUM_W-1:0]              sum_nxt;
  logic [SUM_W-1:0]              sum_mag;
  logic [SUM_W:0]                avg_mag;
  logic [SUM_W:0]                avg_c;
  logic                          flag_c;
  logic                          in_fire;
  logic                          out_free;

  logic                   sqrt_done;
  logic [SAMPLE_BITS-1:0] sqrt_root;
  logic                   div_done;
  logic [SUM_W-1:0]       div_quo;
  logic [EW-1:0]          ram_rd_data;

  assign in_fire  = in_ch.valid && (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ch.ready;

  // shared squaring multiplier on the absolute sample value
  always_comb begin
    case (cnt_r)
      2'd0:    sel = ax_r;
      2'd1:    sel = ay_r;
      default: sel = az_r;
    endcase
    op     = sel[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sel) : SAMPLE_BITS'(sel);
    prod_c = {{SAMPLE_BITS{1'b0}}, op} * {{SAMPLE_BITS{1'b0}}, op};
  end

  // ring entry, running sum update and result forming
  always_comb begin
    entry   = EW'(mag_r) - EW'(gravity_r);
    old_c   = filled_r ? ram_rd_data : '0;
    sum_nxt = sum_r - {{(SUM_W-EW){old_c[EW-1]}}, old_c}
                    + {{(SUM_W-EW){entry[EW-1]}}, entry};
    sum_mag = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : sum_r;
    avg_mag = {1'b0, quo_r};
    avg_c   = neg_r ? (SUM_W+1)'(-avg_mag) : avg_mag;
    flag_c  = (quo_r < {{(SUM_W-CFG_W){1'b0}}, thresh_r});
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gravity_r <= GRAVITY_LEVEL_RST;
      thresh_r  <= ZERO_THRESHOLD_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_GRAVITY_LEVEL:  gravity_r <= cfg_wdata;
        REG_ZERO_THRESHOLD: thresh_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer with its registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      sum_r       <= '0;
      slot_r      <= '0;
      filled_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // result taken; the finish step loads the next one itself
      if (out_valid_r && out_ch.ready && (state_r != ST_FINISH)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            ax_r    <= in_ch.accel_x;
            ay_r    <= in_ch.accel_y;
            az_r    <= in_ch.accel_z;
            cnt_r   <= '0;
            acc_r   <= '0;
            state_r <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          prod_r <= prod_c;
          if (cnt_r != 2'd0) begin
            acc_r <= acc_r + prod_r;
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 2'd3) begin
            state_r <= ST_SQRT_GO;
          end
        end
        ST_SQRT_GO: begin
          state_r <= ST_SQRT_WAIT;
        end
        ST_SQRT_WAIT: begin
          if (sqrt_done) begin
            mag_r   <= sqrt_root;
            state_r <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          sum_r <= sum_nxt;
          if (slot_r == SLOT_LAST) begin
            slot_r   <= '0;
            filled_r <= 1'b1;
          end else begin
            slot_r <= slot_r + 1'b1;
          end
          state_r <= ST_DIV_GO;
        end
        ST_DIV_GO: begin
          neg_r   <= sum_r[SUM_W-1];
          state_r <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            quo_r   <= div_quo;
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_avg_r   <= avg_c[AVG_W-1:0];
            out_flag_r  <= flag_c;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // window ring storage
  mawd_ram #(
    .WIDTH (EW),
    .DEPTH (WINDOW_LENGTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (state_r == ST_UPDATE),
    .wr_addr (slot_r),
    .wr_data (entry),
    .rd_en   (in_fire),
    .rd_addr (slot_r),
    .rd_data (ram_rd_data)
  );

  // magnitude square root
  mawd_sqrt #(
    .ROOT_W (SAMPLE_BITS)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == ST_SQRT_GO),
    .radicand (acc_r),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  // window average divider on the sum magnitude
  mawd_div #(
    .DVD_W   (SUM_W),
    .DIVISOR (WINDOW_LENGTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == ST_DIV_GO),
    .dividend (sum_mag),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign in_ch.ready            = (state_r == ST_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.average_accel   = out_avg_r;
  assign out_ch.apogee_detected = out_flag_r;

endmodule

// ===== tb/mawd_window_checker.sv =====
// checker for the acceleration magnitude window detector: tracks registers, predicts, compares
module mawd_window_checker import mawd_pkg::*; #(
  parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  mawd_in_if                   in_mon,
  mawd_out_if                  out_mon,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   fail_count,
  output int                   results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [AVG_W-1:0] average;
    logic                    apogee;
  } window_result_t;

  // shadow of the block's registers and window
  longint         gravity_now;
  longint         threshold_now;
  longint         window_ring [WINDOW_LENGTH];
  longint         window_sum;
  int             next_slot;
  window_result_t owed_q [$];

  // floor of the square root, one candidate bit at a time from the top
  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned root;
    longint unsigned cand;
    root = 0;
    for (int b = 16; b >= 0; b--) begin
      cand = root | (longint'(1) << b);
      if (cand * cand <= v) root = cand;
    end
    return root;
  endfunction

  function automatic longint unsigned axis_square(input logic signed [SAMPLE_BITS_DEF-1:0] a);
    longint m;
    m = a;
    if (m < 0) m = -m;
    return m * m;
  endfunction

  // fold one sample into the window and work out the average word it yields
  function automatic window_result_t fold_sample(input logic signed [SAMPLE_BITS_DEF-1:0] x,
                                                 input logic signed [SAMPLE_BITS_DEF-1:0] y,
                                                 input logic signed [SAMPLE_BITS_DEF-1:0] z);
    longint         mag;
    longint         entry;
    longint         avg;
    longint         avg_abs;
    window_result_t r;
    mag   = longint'(floor_root(axis_square(x) + axis_square(y) + axis_square(z)));
    entry = mag - gravity_now;
    window_sum = window_sum - window_ring[next_slot] + entry;
    window_ring[next_slot] = entry;
    next_slot = (next_slot == WINDOW_LENGTH - 1) ? 0 : next_slot + 1;
    // integer division truncates toward zero
    avg     = window_sum / WINDOW_LENGTH;
    avg_abs = (avg < 0) ? -avg : avg;
    r.average = avg[AVG_W-1:0];
    r.apogee  = (avg_abs < threshold_now);
    return r;
  endfunction

  // watch register writes and both channels
  always @(posedge clk) begin
    window_result_t want;
    int             errs;
    errs = 0;
    if (!rst_n) begin
      gravity_now   = longint'(GRAVITY_LEVEL_RST);
      threshold_now = longint'(ZERO_THRESHOLD_RST);
      for (int i = 0; i < WINDOW_LENGTH; i++) window_ring[i] = 0;
      window_sum = 0;
      next_slot  = 0;
      owed_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_GRAVITY_LEVEL:  gravity_now   = longint'(cfg_wdata);
          REG_ZERO_THRESHOLD: threshold_now = longint'(cfg_wdata);
          default: ;
        endcase
      end
      // result word against the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        if (owed_q.size() == 0) begin
          $error("result word with none outstanding: average_accel %0d apogee_detected %0b",
                 out_mon.average_accel, out_mon.apogee_detected);
          errs++;
        end else begin
          want = owed_q.pop_front();
          if (out_mon.average_accel !== want.average) begin
            $error("average_accel: expected %0d, actual %0d", want.average,
                   out_mon.average_accel);
            errs++;
          end
          if (out_mon.apogee_detected !== want.apogee) begin
            $error("apogee_detected: expected %0b, actual %0b", want.apogee,
                   out_mon.apogee_detected);
            errs++;
          end
        end
      end
      // sample word accepted
      if (in_mon.valid && in_mon.ready)
        owed_q.push_back(fold_sample(in_mon.accel_x, in_mon.accel_y, in_mon.accel_z));
    end
    if (errs != 0) fail_count <= fail_count + errs;
    results_owed <= owed_q.size();
  end

endmodule

// ===== tb/tb_accel_magnitude_window_detector.sv =====
// testbench top for the acceleration magnitude window detector: stimulus and verdict
module tb_accel_magnitude_window_detector;
  import mawd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // writes to these indexes must be ignored by the block
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

  localparam int BLOCK_LATENCY = 60;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_ITEMS   = 138;

  typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_SPARSE, STALL_LONG} stall_mode_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  int                   fail_count;
  int                   results_owed;
  int                   cycle_count;
  int                   burst_left;
  int                   stall_tick;
  stall_mode_t          stall_mode;
  logic [CFG_W-1:0]     gravity_now;

  mawd_in_if  in_ch ();
  mawd_out_if out_ch ();

  accel_magnitude_window_detector DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  mawd_window_checker window_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("accel_magnitude_window_detector verification failed");
      $finish;
    end
  end

  // result side stalls, switching at regular intervals to a randomly chosen pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_tick   <= 0;
      stall_mode   <= STALL_NONE;
    end else begin
      stall_tick <= stall_tick + 1;
      if (stall_tick % 150 == 149) stall_mode <= stall_mode_t'($urandom_range(0, 3));
      case (stall_mode)
        STALL_NONE:   out_ch.ready <= 1'b1;
        STALL_RANDOM: out_ch.ready <= 1'($urandom_range(0, 1));
        STALL_SPARSE: out_ch.ready <= (stall_tick % 5 == 0);
        default:      out_ch.ready <= (stall_tick % 31 == 0);
      endcase
    end
  end

  function automatic logic signed [15:0] clamp16(input int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] extreme_axis();
    case ($urandom_range(0, 4))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      3:       return 16'shffff;
      default: return 16'sh0001;
    endcase
  endfunction

  // offer one sample word, then either stay in the burst or pause
  task automatic drive_sample(input logic signed [15:0] x, input logic signed [15:0] y,
                              input logic signed [15:0] z);
    in_ch.valid   <= 1'b1;
    in_ch.accel_x <= x;
    in_ch.accel_y <= y;
    in_ch.accel_z <= z;
    do @(posedge clk); while (!in_ch.ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
    end
  endtask

  // wait until every result is back and the block has settled
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (BLOCK_LATENCY) @(posedge clk);
  endtask

  // back-to-back register writes, enable held high across them
  task automatic program_regs(input logic [CFG_W-1:0] grav, input logic [CFG_W-1:0] thr,
                              input bit hit_spare);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [CFG_W-1:0]     val [4];
    int                   n;
    idx[0] = REG_GRAVITY_LEVEL;
    val[0] = grav;
    idx[1] = REG_SPARE_2;
    val[1] = CFG_W'($urandom);
    idx[2] = REG_ZERO_THRESHOLD;
    val[2] = thr;
    idx[3] = REG_SPARE_3;
    val[3] = CFG_W'($urandom);
    n = 4;
    for (int i = 0; i < n; i++) begin
      if (hit_spare || (idx[i] == REG_GRAVITY_LEVEL) || (idx[i] == REG_ZERO_THRESHOLD)) begin
        cfg_wr_en <= 1'b1;
        cfg_index <= idx[i];
        cfg_wdata <= val[i];
        @(posedge clk);
      end
    end
    cfg_wr_en   <= 1'b0;
    gravity_now = grav;
  endtask

  // four in ten samples near the gravity level, to pull the average toward zero
  task automatic pick_sample(output logic signed [15:0] x, output logic signed [15:0] y,
                             output logic signed [15:0] z);
    int                 g_off;
    logic signed [15:0] big;
    logic signed [15:0] s1;
    logic signed [15:0] s2;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        g_off = int'(gravity_now) + int'($urandom_range(0, 600)) - 300;
        big   = clamp16($urandom_range(0, 1) ? g_off : -g_off);
        s1    = clamp16(int'($urandom_range(0, 400)) - 200);
        s2    = clamp16(int'($urandom_range(0, 400)) - 200);
        case ($urandom_range(0, 2))
          0:       begin x = big; y = s1;  z = s2;  end
          1:       begin x = s1;  y = big; z = s2;  end
          default: begin x = s1;  y = s2;  z = big; end
        endcase
      end
      4, 5, 6: begin
        x = 16'($urandom);
        y = 16'($urandom);
        z = 16'($urandom);
      end
      7, 8: begin
        x = extreme_axis();
        y = extreme_axis();
        z = extreme_axis();
      end
      default: begin
        x = clamp16(int'($urandom_range(0, 64)) - 32);
        y = clamp16(int'($urandom_range(0, 64)) - 32);
        z = clamp16(int'($urandom_range(0, 64)) - 32);
      end
    endcase
  endtask

  task automatic run_random(input int n);
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    for (int i = 0; i < n; i++) begin
      pick_sample(x, y, z);
      drive_sample(x, y, z);
    end
  endtask

  // directed words under reset register values, window still filling
  task automatic run_directed();
    drive_sample(16'sd0, 16'sd0, 16'sd0);
    drive_sample(16'sd0, 16'sd0, 16'sd0);
    drive_sample(16'sh8000, 16'sh8000, 16'sh8000);
    drive_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
    drive_sample(16'sh8000, 16'sh7fff, 16'sd0);
    drive_sample(16'sh7fff, 16'sd0, 16'sd0);
    drive_sample(16'sd0, 16'sh8000, 16'sd0);
    drive_sample(16'sd0, 16'sd0, 16'sh8000);
    drive_sample(16'sd3, 16'sd4, 16'sd0);
    drive_sample(16'sd0, -16'sd3, -16'sd4);
    drive_sample(16'sd1, 16'sd1, 16'sd1);
    drive_sample(-16'sd1, 16'sd0, 16'sd0);
    drive_sample(16'sd2, 16'sd2, 16'sd1);
    drive_sample(16'sd0, 16'sd0, 16'sd2047);
    drive_sample(16'sd0, 16'sd0, 16'sd2048);
    drive_sample(16'sd0, 16'sd0, 16'sd2049);
    drive_sample(16'sd1229, 16'sd1638, 16'sd0);
    // run of samples right at gravity drags the average toward zero
    repeat (8) drive_sample(16'sd0, 16'sd0, -16'sd2048);
  endtask

  // stimulus and verdict
  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.accel_x <= '0;
    in_ch.accel_y <= '0;
    in_ch.accel_z <= '0;
    cfg_wr_en     <= 1'b0;
    cfg_index     <= '0;
    cfg_wdata     <= '0;
    burst_left    = 0;
    gravity_now   = GRAVITY_LEVEL_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    drain();

    // zero threshold never flags
    program_regs(CFG_W'(0), CFG_W'(0), 1'b1);
    run_random(PHASE_ITEMS);
    drain();

    program_regs(CFG_W'(65535), CFG_W'(65535), 1'b0);
    run_random(PHASE_ITEMS);
    drain();

    program_regs(GRAVITY_LEVEL_RST, ZERO_THRESHOLD_RST, 1'b1);
    run_random(PHASE_ITEMS);
    drain();

    program_regs(CFG_W'($urandom), CFG_W'($urandom), 1'b0);
    run_random(PHASE_ITEMS);
    drain();

    program_regs(CFG_W'(16384), CFG_W'(1000), 1'b1);
    run_random(PHASE_ITEMS);
    drain();

    program_regs(CFG_W'($urandom_range(0, 4096)), CFG_W'($urandom_range(0, 2000)), 1'b0);
    run_random(PHASE_ITEMS);
    drain();

    if (fail_count == 0) begin
      $display("accel_magnitude_window_detector verification clean");
    end else begin
      $display("accel_magnitude_window_detector verification failed");
    end
    $finish;
  end

endmodule
